/* hdl/cci_pkg.sv */
// Shared types, widths and helpers for the curve crossing interpolator.
// No dependencies; every other file imports this package.
`default_nettype none

package cci_pkg;

	localparam int VALUE_W = 32;            // sample and result width
	localparam int DIFF_W  = VALUE_W + 1;   // exact difference of two values
	localparam int SUM_W   = VALUE_W + 2;   // |d0| + |d1|
	localparam int T_BITS  = 32;            // fraction bits of t
	localparam int CNT_W   = $clog2(T_BITS);

	typedef struct packed {
		logic signed [VALUE_W-1:0] sample_x;
		logic signed [VALUE_W-1:0] first_value;
		logic signed [VALUE_W-1:0] second_value;
		logic                      end_of_curves;
	} sample_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] crossing_x;
		logic signed [VALUE_W-1:0] crossing_y;
	} crossing_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request and update previous sample
		logic diff;      // form the four differences
		logic setup;     // magnitudes, divider operands
		logic div_step;  // one quotient bit
		logic mul_x;     // x product
		logic mul_y;     // y product, finish x
		logic add_y;     // finish y
		logic out_load;  // move result into output register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic crossing;  // valid during setup
	} dp_status_t;

	function automatic logic [DIFF_W-1:0] mag_f(input logic [DIFF_W-1:0] v);
		mag_f = v[DIFF_W-1] ? (~v + 1'b1) : v;
	endfunction

endpackage

`default_nettype wire

/* hdl/cci_datapath.sv */
// Datapath: previous-sample storage, differences, restoring divider for t,
// shared multiplier for both interpolations, output register. Uses cci_pkg.
`default_nettype none

module cci_datapath
	import cci_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire sample_t    sample,
	input  wire dp_cmd_t    cmd,
	output      dp_status_t status,
	output      crossing_t  result
);

	// previous sample
	logic signed [VALUE_W-1:0] prior_x_q, prior_first_q, prior_second_q;
	logic                      prior_valid_q;

	// captured operands of the current request
	logic signed [VALUE_W-1:0] op_px_q, op_pf_q, op_ps_q, op_x_q, op_f_q, op_s_q;
	logic                      op_valid_q;

	logic signed [DIFF_W-1:0]  d0_q, d1_q, dx_q, dy_q;
	logic [DIFF_W-1:0]         mag_x_q, mag_y_q;
	logic                      neg_x_q, neg_y_q;

	logic [SUM_W-1:0]          den_q, rem_q;
	logic [T_BITS-1:0]         quo_q;
	logic [2*T_BITS-1:0]       prod_q;
	logic signed [VALUE_W-1:0] res_x_q, res_y_q;
	crossing_t                 out_q;

	logic [DIFF_W-1:0]         mag_d0, mag_d1;
	logic [SUM_W:0]            rem_sh;
	logic [SUM_W:0]            den_ext;
	logic [DIFF_W-1:0]         mul_src;
	logic [2*T_BITS-1:0]       product;

	// a0 +/- floor(|a1 - a0| * t / 2^32); high magnitude bit contributes t itself
	function automatic logic signed [VALUE_W-1:0] lerp_f(
		input logic signed [VALUE_W-1:0] a0,
		input logic                      hi,
		input logic                      neg,
		input logic [2*T_BITS-1:0]       prod,
		input logic [T_BITS-1:0]         t
	);
		logic [T_BITS:0]  off;
		logic [SUM_W-1:0] r;
		off = (hi ? {1'b0, t} : '0) + {1'b0, prod[2*T_BITS-1:T_BITS]};
		r = neg ? (SUM_W'(a0) - SUM_W'(off)) : (SUM_W'(a0) + SUM_W'(off));
		lerp_f = r[VALUE_W-1:0];
	endfunction

	assign status.crossing = op_valid_q && (d0_q != '0) && (d1_q != '0)
		&& (d0_q[DIFF_W-1] != d1_q[DIFF_W-1]);

	assign mag_d0  = mag_f(d0_q);
	assign mag_d1  = mag_f(d1_q);
	assign rem_sh  = {rem_q, 1'b0};
	assign den_ext = {1'b0, den_q};
	assign mul_src = cmd.mul_x ? mag_x_q : mag_y_q;
	assign product = (2*T_BITS)'(mul_src[T_BITS-1:0]) * (2*T_BITS)'(quo_q);
	assign result  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_x_q      <= '0;
			prior_first_q  <= '0;
			prior_second_q <= '0;
			prior_valid_q  <= 1'b0;
		end else if (cmd.load) begin
			if (sample.end_of_curves) begin
				prior_x_q      <= '0;
				prior_first_q  <= '0;
				prior_second_q <= '0;
				prior_valid_q  <= 1'b0;
			end else begin
				prior_x_q      <= sample.sample_x;
				prior_first_q  <= sample.first_value;
				prior_second_q <= sample.second_value;
				prior_valid_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_px_q    <= prior_x_q;
			op_pf_q    <= prior_first_q;
			op_ps_q    <= prior_second_q;
			op_x_q     <= sample.sample_x;
			op_f_q     <= sample.first_value;
			op_s_q     <= sample.second_value;
			op_valid_q <= prior_valid_q;
		end
		if (cmd.diff) begin
			d0_q <= DIFF_W'(op_pf_q) - DIFF_W'(op_ps_q);
			d1_q <= DIFF_W'(op_f_q) - DIFF_W'(op_s_q);
			dx_q <= DIFF_W'(op_x_q) - DIFF_W'(op_px_q);
			dy_q <= DIFF_W'(op_f_q) - DIFF_W'(op_pf_q);
		end
		if (cmd.setup) begin
			den_q   <= SUM_W'(mag_d0) + SUM_W'(mag_d1);
			rem_q   <= SUM_W'(mag_d0);
			quo_q   <= '0;
			mag_x_q <= mag_f(dx_q);
			neg_x_q <= dx_q[DIFF_W-1];
			mag_y_q <= mag_f(dy_q);
			neg_y_q <= dy_q[DIFF_W-1];
		end
		if (cmd.div_step) begin
			// remainder stays below den, so the shifted value fits and the
			// difference fits back in SUM_W bits
			if (rem_sh >= den_ext) begin
				rem_q <= SUM_W'(rem_sh - den_ext);
				quo_q <= {quo_q[T_BITS-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[SUM_W-1:0];
				quo_q <= {quo_q[T_BITS-2:0], 1'b0};
			end
		end
		if (cmd.mul_x || cmd.mul_y)
			prod_q <= product;
		if (cmd.mul_y)
			res_x_q <= lerp_f(op_px_q, mag_x_q[DIFF_W-1], neg_x_q, prod_q, quo_q);
		if (cmd.add_y)
			res_y_q <= lerp_f(op_pf_q, mag_y_q[DIFF_W-1], neg_y_q, prod_q, quo_q);
		if (cmd.out_load) begin
			out_q.crossing_x <= res_x_q;
			out_q.crossing_y <= res_y_q;
		end
	end

endmodule

`default_nettype wire

/* hdl/cci_ctrl.sv */
// Controller: sequences accept, difference, divide, multiply and output
// steps, and owns both handshakes. Uses cci_pkg.
`default_nettype none

module cci_ctrl
	import cci_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       sample_valid,
	output      logic       sample_stall,
	output      logic       crossing_valid,
	input  wire logic       crossing_stall,
	input  wire dp_status_t status,
	output      dp_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIFF  = 3'd1;
	localparam logic [2:0] ST_SETUP = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_MUL_X = 3'd4;
	localparam logic [2:0] ST_MUL_Y = 3'd5;
	localparam logic [2:0] ST_ADD_Y = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign sample_stall   = (state_q != ST_IDLE);
	assign crossing_valid = out_valid_q;
	assign out_free       = !out_valid_q || !crossing_stall;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_SETUP;
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = status.crossing ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(T_BITS - 1))
					state_d = ST_MUL_X;
			end
			ST_MUL_X: begin
				cmd.mul_x = 1'b1;
				state_d   = ST_MUL_Y;
			end
			ST_MUL_Y: begin
				cmd.mul_y = 1'b1;
				state_d   = ST_ADD_Y;
			end
			ST_ADD_Y: begin
				cmd.add_y = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.setup)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + 1'b1;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!crossing_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

/* hdl/curve_crossing_interpolator_top.sv */
// Channel    Direction  Handshake                       Payload
// sample     in         sample_valid / sample_stall     sample_t (x, two values, end flag)
// crossing   out        crossing_valid / crossing_stall crossing_t (x, y)
//
// A sample without a crossing passes accept, difference and setup only; one with a
// crossing also runs the restoring divider, forming t one quotient bit per cycle.
// The result register frees the core: the next sample is taken while a result
// still waits. A stalled result holds the core in its last step only.
// Reset clears the previous sample and all handshake state.
// Top level; depends on cci_pkg, cci_ctrl and cci_datapath.
`default_nettype none

module curve_crossing_interpolator_top
	import cci_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      sample_valid,
	output      logic      sample_stall,
	input  wire sample_t   sample,
	output      logic      crossing_valid,
	input  wire logic      crossing_stall,
	output      crossing_t crossing
);

	dp_cmd_t    cmd;
	dp_status_t status;

	cci_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.crossing_valid (crossing_valid),
		.crossing_stall (crossing_stall),
		.status         (status),
		.cmd            (cmd)
	);

	cci_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.cmd    (cmd),
		.status (status),
		.result (crossing)
	);

endmodule

`default_nettype wire

/* hdl/cci_checker.sv */
// Port-level checks for the curve crossing interpolator, bound to the top.
// Depends on cci_pkg.
`default_nettype none

module cci_checker
	import cci_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      sample_valid,
	input wire logic      sample_stall,
	input wire sample_t   sample,
	input wire logic      crossing_valid,
	input wire logic      crossing_stall,
	input wire crossing_t crossing
);

	// every request keeps the core busy for at least the following cycle
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> sample_stall)
		else $error("request taken back to back");

	// a stalled request keeps its payload until taken
	a_request_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && sample_stall) |=> (sample_valid && $stable(sample)))
		else $error("stalled request changed");

	// a fresh result only shows up while the core is busy
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(crossing_valid) |-> $past(sample_stall))
		else $error("result appeared from an idle core");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(crossing_valid && crossing_stall) |=> (crossing_valid && $stable(crossing)))
		else $error("stalled result changed");

	a_result_not_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(crossing_valid) |-> $past(!crossing_stall))
		else $error("result withdrawn without being taken");

endmodule

bind curve_crossing_interpolator_top cci_checker u_cci_checker (.*);

`default_nettype wire
